>>> hdl/mi3_pkg.sv
// Package for the 3x3 matrix inverse: widths, payload types and queue sizing.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package mi3_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int N_ELEM      = 9;
    localparam int W_E         = 32;
    localparam int W_Q         = 32;
    localparam int W_P         = 2 * W_E;
    localparam int W_COF       = W_P + 1;
    localparam int LO_BITS     = W_COF - W_E;
    localparam int W_DLO       = W_E + LO_BITS + 1;
    localparam int W_DHI       = 2 * W_E;
    localparam int W_T         = W_E + W_COF;
    localparam int W_DET       = W_T + 2;
    localparam int W_CMAG      = W_COF;
    localparam int W_DMAG      = W_DET;
    localparam int DIV_STAGES  = W_Q;
    localparam int W_R_DEN     = W_DMAG + W_Q + 1;
    localparam int W_R_NUM     = W_CMAG + 2 * FRAC_BITS;
    localparam int W_R         = (W_R_DEN > W_R_NUM) ? W_R_DEN : W_R_NUM;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [N_ELEM-1:0][W_E-1:0] t_mat;
    typedef logic [DIV_STAGES:0][W_DMAG-1:0] t_dpipe;

    typedef struct packed {
        t_mat                           mat;
        logic [N_ELEM-1:0][W_CMAG-1:0]  num;
        logic [N_ELEM-1:0]              neg;
        logic [W_DMAG-1:0]              den;
        logic                           sing;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> hdl/mi3_if.sv
// Channel interfaces of the 3x3 matrix inverse: input matrix and result matrix.
// Depends on mi3_pkg for the element width.
`timescale 1ns / 1ps

interface mi3_in_if import mi3_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic signed [W_E-1:0] in_r0c0;
    logic signed [W_E-1:0] in_r0c1;
    logic signed [W_E-1:0] in_r0c2;
    logic signed [W_E-1:0] in_r1c0;
    logic signed [W_E-1:0] in_r1c1;
    logic signed [W_E-1:0] in_r1c2;
    logic signed [W_E-1:0] in_r2c0;
    logic signed [W_E-1:0] in_r2c1;
    logic signed [W_E-1:0] in_r2c2;

    modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                    in_r2c0, in_r2c1, in_r2c2, input ready);
    modport sink   (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                    in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface mi3_out_if import mi3_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic signed [W_Q-1:0] out_r0c0;
    logic signed [W_Q-1:0] out_r0c1;
    logic signed [W_Q-1:0] out_r0c2;
    logic signed [W_Q-1:0] out_r1c0;
    logic signed [W_Q-1:0] out_r1c1;
    logic signed [W_Q-1:0] out_r1c2;
    logic signed [W_Q-1:0] out_r2c0;
    logic signed [W_Q-1:0] out_r2c1;
    logic signed [W_Q-1:0] out_r2c2;
    logic                  singular;

    modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                    out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, input ready);
    modport sink   (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                    out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, output ready);
endinterface

>>> hdl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by the adjugate, signed fixed point, saturated results.
// Throughput is one matrix per cycle while the output is not stalled; the 32-stage
// restoring divider lanes set the depth.
// A two-entry queue lets the front end keep taking transfers while the output stalls.
// Reset clears the valid bits and the queue pointers and count only; payload registers are not reset.
// Depends on mi3_pkg, mi3_if, mi3_front, mi3_queue, mi3_div_lane and mi3_back.
`timescale 1ns / 1ps

module matrix_inverse_3x3 import mi3_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mi3_in_if.sink    i_in,
    mi3_out_if.source o_out
);

    logic   f_vld;
    t_job   f_job;
    t_job   q_job;
    t_qstat qst;
    logic   push;
    logic   pop;

    assign push = f_vld && !qst.full;

    mi3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (qst.full),
        .o_vld   (f_vld),
        .o_job   (f_job)
    );

    mi3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_stat  (qst)
    );

    mi3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (qst.empty),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qst.full && qst.empty))
        else $error("Queue reports full and empty at once.");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qst.empty)
        else $error("Back end popped an empty queue.");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> !qst.empty)
        else $error("Queue is empty after a push without a pop.");

    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> !qst.full)
        else $error("Queue is still full after a pop without a push.");

endmodule

>>> hdl/mi3_front.sv
// Front end: accepts matrices, forms cofactors and the determinant, classifies
// singular matrices and hands a job to the queue. Depends on mi3_pkg, mi3_if.
`timescale 1ns / 1ps

module mi3_front import mi3_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mi3_in_if.sink    i_in,
    input  logic      i_full,
    output logic      o_vld,
    output t_job      o_job
);

    logic signed [W_E-1:0]   m [N_ELEM];
    logic                    en;
    logic [6:1]              r_vld;
    t_mat                    r_mat [1:5];
    logic signed [W_P-1:0]   r_pp [N_ELEM];
    logic signed [W_P-1:0]   r_ps [N_ELEM];
    logic signed [W_COF-1:0] r_cof [2:5][N_ELEM];
    logic signed [W_DLO-1:0] r_dlo [3];
    logic signed [W_DHI-1:0] r_dhi [3];
    logic signed [W_T-1:0]   r_term [3];
    logic signed [W_DET-1:0] r_det;
    t_job                    r_job;
    t_job                    n_job;

    assign m[0] = i_in.in_r0c0;
    assign m[1] = i_in.in_r0c1;
    assign m[2] = i_in.in_r0c2;
    assign m[3] = i_in.in_r1c0;
    assign m[4] = i_in.in_r1c1;
    assign m[5] = i_in.in_r1c2;
    assign m[6] = i_in.in_r2c0;
    assign m[7] = i_in.in_r2c1;
    assign m[8] = i_in.in_r2c2;

    assign en         = !r_vld[6] || !i_full;
    assign i_in.ready = en;
    assign o_vld      = r_vld[6];
    assign o_job      = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[5:1], i_in.valid};
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam int I1 = (gi + 1) % 3;
            localparam int I2 = (gi + 2) % 3;
            localparam int J1 = (gj + 1) % 3;
            localparam int J2 = (gj + 2) % 3;
            localparam int K  = gi * 3 + gj;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_pp[K]     <= m[I1 * 3 + J1] * m[I2 * 3 + J2];
                    r_ps[K]     <= m[I1 * 3 + J2] * m[I2 * 3 + J1];
                    r_cof[2][K] <= W_COF'(r_pp[K]) - W_COF'(r_ps[K]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mat[1] <= {m[8], m[7], m[6], m[5], m[4], m[3], m[2], m[1], m[0]};
            for (int s = 2; s <= 5; s++) begin
                r_mat[s] <= r_mat[s-1];
            end
            r_cof[3] <= r_cof[2];
            r_cof[4] <= r_cof[3];
            r_cof[5] <= r_cof[4];
            for (int j = 0; j < 3; j++) begin
                r_dlo[j]  <= $signed(r_mat[2][j]) *
                             $signed({1'b0, r_cof[2][j][LO_BITS-1:0]});
                r_dhi[j]  <= $signed(r_mat[2][j]) * $signed(r_cof[2][j][W_COF-1:LO_BITS]);
                r_term[j] <= (W_T'(r_dhi[j]) <<< LO_BITS) + W_T'(r_dlo[j]);
            end
            r_det <= W_DET'(r_term[0]) + W_DET'(r_term[1]) + W_DET'(r_term[2]);
            r_job <= n_job;
        end
    end

    always_comb begin
        n_job.mat  = r_mat[5];
        n_job.sing = (r_det == '0);
        n_job.den  = r_det[W_DET-1] ? W_DMAG'(-r_det) : W_DMAG'(r_det);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_job.num[i*3+j] = r_cof[5][j*3+i][W_COF-1] ? W_CMAG'(-r_cof[5][j*3+i])
                                                            : W_CMAG'(r_cof[5][j*3+i]);
                n_job.neg[i*3+j] = r_cof[5][j*3+i][W_COF-1] ^ r_det[W_DET-1];
            end
        end
    end

endmodule

>>> hdl/mi3_queue.sv
// Short job queue between the front end and the divider back end.
// Depends on mi3_pkg for the job type and depth.
`timescale 1ns / 1ps

module mi3_queue import mi3_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_stat
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

>>> hdl/mi3_div_lane.sv
// One pipelined divider lane: scaled cofactor magnitude over determinant magnitude,
// one quotient bit per stage, then rounding. Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_div_lane import mi3_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [W_CMAG-1:0] i_num,
    input  logic              i_neg,
    input  logic [W_DMAG-1:0] i_den,
    input  t_dpipe            i_den_pipe,
    output logic [W_Q:0]      o_q,
    output logic              o_ovf,
    output logic              o_neg
);

    logic [W_R-1:0] r_rem [DIV_STAGES+1];
    logic [W_Q-1:0] r_q   [DIV_STAGES+1];
    logic           r_ovf [DIV_STAGES+1];
    logic           r_neg [DIV_STAGES+1];
    logic [W_R-1:0] num_ext;
    logic [W_R-1:0] den_top;
    logic           rnd;
    logic [W_Q:0]   r_qr;
    logic           r_ovf_o;
    logic           r_neg_o;

    assign num_ext = W_R'({i_num, {(2 * FRAC_BITS){1'b0}}});
    assign den_top = W_R'(i_den) << W_Q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= num_ext;
            r_q[0]   <= '0;
            r_ovf[0] <= (num_ext >= den_top);
            r_neg[0] <= i_neg;
        end
    end

    for (genvar gs = 0; gs < DIV_STAGES; gs++) begin : g_stage
        logic [W_R-1:0] trial;
        logic           ge;
        assign trial = W_R'(i_den_pipe[gs]) << (W_Q - 1 - gs);
        assign ge    = (r_rem[gs] >= trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gs+1] <= ge ? r_rem[gs] - trial : r_rem[gs];
                r_q[gs+1]   <= r_q[gs] | (ge ? (W_Q'(1) << (W_Q - 1 - gs)) : '0);
                r_ovf[gs+1] <= r_ovf[gs];
                r_neg[gs+1] <= r_neg[gs];
            end
        end
    end

    assign rnd = ({r_rem[DIV_STAGES], 1'b0} >= (W_R + 1)'(i_den_pipe[DIV_STAGES]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qr    <= (W_Q + 1)'(r_q[DIV_STAGES]) + (W_Q + 1)'(rnd);
            r_ovf_o <= r_ovf[DIV_STAGES];
            r_neg_o <= r_neg[DIV_STAGES];
        end
    end

    assign o_q   = r_qr;
    assign o_ovf = r_ovf_o;
    assign o_neg = r_neg_o;

endmodule

>>> hdl/mi3_back.sv
// Back end: nine divider lanes, saturation, singular pass-through and the
// output register. Depends on mi3_pkg, mi3_if and mi3_div_lane.
`timescale 1ns / 1ps

module mi3_back import mi3_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_job,
    output logic       o_pop,
    mi3_out_if.source  o_out
);

    localparam int B_LAST = DIV_STAGES + 1;

    logic           en;
    logic           r_vld  [B_LAST+1];
    logic           r_sing [B_LAST+1];
    t_mat           r_mat  [B_LAST+1];
    t_dpipe         r_den;
    logic [W_Q:0]   lq   [N_ELEM];
    logic           lovf [N_ELEM];
    logic           lneg [N_ELEM];
    logic           r_out_vld;
    logic           r_out_sing;
    t_mat           r_out_mat;

    function automatic logic [W_Q-1:0] f_sat(input logic [W_Q:0] q, input logic ovf,
                                              input logic neg);
        logic [W_Q:0] half;
        half = (W_Q + 1)'(1) << (W_Q - 1);
        if (neg) begin
            if (ovf || (q > half)) begin
                return {1'b1, {(W_Q - 1){1'b0}}};
            end
            return W_Q'(-q);
        end
        if (ovf || (q >= half)) begin
            return {1'b0, {(W_Q - 1){1'b1}}};
        end
        return W_Q'(q);
    endfunction

    assign en    = !r_out_vld || o_out.ready;
    assign o_pop = en && !i_empty;

    for (genvar gk = 0; gk < N_ELEM; gk++) begin : g_lane
        mi3_div_lane u_lane (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_num      (i_job.num[gk]),
            .i_neg      (i_job.neg[gk]),
            .i_den      (i_job.den),
            .i_den_pipe (r_den),
            .o_q        (lq[gk]),
            .o_ovf      (lovf[gk]),
            .o_neg      (lneg[gk])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= B_LAST; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld[0] <= !i_empty;
            for (int s = 0; s < B_LAST; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
            r_out_vld <= r_vld[B_LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mat[0]  <= i_job.mat;
            r_sing[0] <= i_job.sing;
            r_den[0]  <= i_job.den;
            for (int s = 0; s < B_LAST; s++) begin
                r_mat[s+1]  <= r_mat[s];
                r_sing[s+1] <= r_sing[s];
            end
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_den[s+1] <= r_den[s];
            end
            for (int k = 0; k < N_ELEM; k++) begin
                r_out_mat[k] <= r_sing[B_LAST] ? r_mat[B_LAST][k]
                                               : f_sat(lq[k], lovf[k], lneg[k]);
            end
            r_out_sing <= r_sing[B_LAST];
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.singular = r_out_sing;
    assign o_out.out_r0c0 = r_out_mat[0];
    assign o_out.out_r0c1 = r_out_mat[1];
    assign o_out.out_r0c2 = r_out_mat[2];
    assign o_out.out_r1c0 = r_out_mat[3];
    assign o_out.out_r1c1 = r_out_mat[4];
    assign o_out.out_r1c2 = r_out_mat[5];
    assign o_out.out_r2c0 = r_out_mat[6];
    assign o_out.out_r2c1 = r_out_mat[7];
    assign o_out.out_r2c2 = r_out_mat[8];

endmodule
